[rtl/ansi_terminal_byte_processor_unit_macros.svh]
// assertion macros shared by the terminal byte processor modules
// depends on nothing; included by files that carry assertions
`ifndef ANSI_TERMINAL_BYTE_PROCESSOR_UNIT_MACROS_SVH
`define ANSI_TERMINAL_BYTE_PROCESSOR_UNIT_MACROS_SVH
// assert that a implies b on the same edge
`define ATBP_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// assert that a implies b on the next edge
`define ATBP_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

[rtl/atbp_pkg.sv]
// shared types and constants of the terminal byte processor
// no dependencies
`timescale 1ns / 1ps
package atbp_pkg;
    localparam int MAX_PARAMS_DEF = 16;
    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [7:0] ROWS_RESET = 8'd25;
    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_CUP = 8'h48;
    localparam logic [7:0] CH_SGR = 8'h6D;
    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] SGR_ABORT = 8'd107;
    localparam logic [7:0] SGR_FG_BASE = 8'd30;
    localparam logic [7:0] SGR_BG_BASE = 8'd40;
    localparam logic [0:0] EV_DRAW = 1'b0;
    localparam logic [0:0] EV_SCROLL = 1'b1;
    localparam logic [1:0] REG_COLS = 2'd0;
    localparam logic [1:0] REG_ROWS = 2'd1;

    typedef enum logic [1:0] { PH_TEXT, PH_ESC, PH_CSI } phase_t;
    typedef enum logic [2:0] { CMD_BS, CMD_LF, CMD_CR, CMD_PRINT, CMD_CUP, CMD_SGR }
        cmd_kind_t;
    typedef enum logic [1:0] { BK_IDLE, BK_SGR, BK_OUT } back_state_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [6:0] symbol;
    } cmd_t;

    typedef struct packed {
        logic       busy;
        logic       walking;
    } back_status_t;
endpackage

[rtl/atbp_front.sv]
// front part: escape phase tracking and csi parameter collection
// depends on atbp_pkg
`timescale 1ns / 1ps
module atbp_front #(
    parameter int MAX_PARAMS = atbp_pkg::MAX_PARAMS_DEF,
    parameter int PW = $clog2(MAX_PARAMS + 1),
    parameter int IW = $clog2(MAX_PARAMS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    output logic                 q_push,
    output atbp_pkg::cmd_t       q_cmd,
    input  logic                 q_full,
    input  atbp_pkg::back_status_t bstat,
    input  logic [IW-1:0]        prm_raddr,
    output logic [7:0]           prm_rdata,
    output logic [7:0]           prm_rdata1,
    output logic [PW-1:0]        prm_count
);
    atbp_pkg::phase_t phase_reg, phase_next;
    logic [7:0] prm_mem [MAX_PARAMS];
    logic [PW-1:0] count_reg, count_next;
    logic malformed_reg, malformed_next;
    logic [7:0] last_reg, last_next;
    logic wr_en;
    logic wr_zero1;
    logic [IW-1:0] wr_addr;
    logic [7:0] wr_data;
    logic [11:0] acc;
    logic take;
    logic csi_final;

    // the parameter buffer and count must stay put while the back part uses them,
    // so every byte after an esc waits until the queue is empty and the walk is done
    assign csi_final = (phase_reg == atbp_pkg::PH_CSI)
        && !(in_byte >= 8'h20 && in_byte <= 8'h3F);
    assign in_ready = !q_full && !(csi_final && bstat.busy)
        && !((phase_reg != atbp_pkg::PH_TEXT) && bstat.walking);
    assign take = in_valid && in_ready;
    assign prm_count = count_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prm_mem[wr_addr] <= wr_data;
        end
        if (wr_zero1)
        begin
            prm_mem[1] <= '0;
        end
    end
    assign prm_rdata = prm_mem[prm_raddr];
    assign prm_rdata1 = prm_mem[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= atbp_pkg::PH_TEXT;
            count_reg <= '0;
            malformed_reg <= 1'b0;
            last_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            malformed_reg <= malformed_next;
            last_reg <= last_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        malformed_next = malformed_reg;
        last_next = last_reg;
        wr_en = 1'b0;
        wr_zero1 = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        acc = '0;
        q_push = 1'b0;
        q_cmd.kind = atbp_pkg::CMD_PRINT;
        q_cmd.symbol = in_byte[6:0];
        if (take)
        begin
            unique case (phase_reg)
                atbp_pkg::PH_ESC:
                begin
                    if (in_byte == atbp_pkg::CH_LBRACKET)
                    begin
                        phase_next = atbp_pkg::PH_CSI;
                        count_next = '0;
                        malformed_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = atbp_pkg::PH_TEXT;
                    end
                end
                atbp_pkg::PH_CSI:
                begin
                    if (in_byte >= 8'h20 && in_byte <= 8'h3F)
                    begin
                        if (!malformed_reg)
                        begin
                            if (in_byte >= 8'h30 && in_byte <= 8'h39)
                            begin
                                // current field value kept in last_reg
                                if (count_reg == '0)
                                begin
                                    acc = 12'(in_byte - 8'h30);
                                    count_next = PW'(1);
                                    wr_addr = '0;
                                end
                                else
                                begin
                                    acc = 12'(last_reg) * 12'd10 + 12'(in_byte - 8'h30);
                                    wr_addr = IW'(count_reg - PW'(1));
                                end
                                wr_en = 1'b1;
                                wr_data = (acc > 12'd255) ? 8'd255 : acc[7:0];
                                last_next = wr_data;
                            end
                            else if (in_byte == atbp_pkg::CH_SEMI)
                            begin
                                if (count_reg == '0)
                                begin
                                    // implicit empty first field, then the second
                                    wr_en = 1'b1;
                                    wr_addr = '0;
                                    wr_data = '0;
                                    wr_zero1 = 1'b1;
                                    count_next = PW'(2);
                                    last_next = '0;
                                end
                                else if (count_reg < PW'(MAX_PARAMS))
                                begin
                                    wr_en = 1'b1;
                                    wr_addr = IW'(count_reg);
                                    wr_data = '0;
                                    count_next = count_reg + PW'(1);
                                    last_next = '0;
                                end
                                else
                                begin
                                    malformed_next = 1'b1;
                                end
                            end
                            else
                            begin
                                malformed_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        phase_next = atbp_pkg::PH_TEXT;
                        if (in_byte == atbp_pkg::CH_CUP)
                        begin
                            q_push = 1'b1;
                            q_cmd.kind = atbp_pkg::CMD_CUP;
                        end
                        else if (in_byte == atbp_pkg::CH_SGR)
                        begin
                            q_push = 1'b1;
                            q_cmd.kind = atbp_pkg::CMD_SGR;
                        end
                    end
                end
                default:
                begin
                    if (in_byte == atbp_pkg::CH_ESC)
                    begin
                        phase_next = atbp_pkg::PH_ESC;
                    end
                    else if (in_byte == atbp_pkg::CH_BS)
                    begin
                        q_push = 1'b1;
                        q_cmd.kind = atbp_pkg::CMD_BS;
                    end
                    else if (in_byte == atbp_pkg::CH_LF)
                    begin
                        q_push = 1'b1;
                        q_cmd.kind = atbp_pkg::CMD_LF;
                    end
                    else if (in_byte == atbp_pkg::CH_CR)
                    begin
                        q_push = 1'b1;
                        q_cmd.kind = atbp_pkg::CMD_CR;
                    end
                    else if (in_byte >= 8'h20 && in_byte != 8'h7F)
                    begin
                        q_push = 1'b1;
                        q_cmd.symbol = in_byte[7] ? 7'h3F : in_byte[6:0];
                    end
                end
            endcase
        end
    end
endmodule

[rtl/atbp_queue.sv]
// two entry command queue between front and back parts
// depends on atbp_pkg
`timescale 1ns / 1ps
module atbp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  atbp_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output atbp_pkg::cmd_t head
);
    atbp_pkg::cmd_t slot_reg [2];
    logic [1:0] cnt_reg;
    logic rd_reg, wr_reg;

    assign full = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    `include "ansi_terminal_byte_processor_unit_macros.svh"
    `ATBP_ASSERT_IMPL(a_no_overflow, clk, rst_n, full, !push || pop)
    `ATBP_ASSERT_IMPL(a_no_underflow, clk, rst_n, !not_empty, !pop)
    `ATBP_ASSERT_NEXT(a_cnt_range, clk, rst_n, 1'b1, cnt_reg != 2'd3)
endmodule

[rtl/atbp_back.sv]
// back part: cursor, colours, sgr walk and the output register
// depends on atbp_pkg
`timescale 1ns / 1ps
module atbp_back #(
    parameter int MAX_PARAMS = atbp_pkg::MAX_PARAMS_DEF,
    parameter int PW = $clog2(MAX_PARAMS + 1),
    parameter int IW = $clog2(MAX_PARAMS)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     cols,
    input  logic [7:0]     rows,
    input  logic           in_take,
    input  logic           q_valid,
    input  atbp_pkg::cmd_t q_head,
    output logic           q_pop,
    output atbp_pkg::back_status_t bstat,
    output logic [IW-1:0]  prm_raddr,
    input  logic [7:0]     prm_rdata,
    input  logic [7:0]     prm_rdata1,
    input  logic [PW-1:0]  prm_count,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    out_data
);
    atbp_pkg::back_state_t st_reg, st_next;
    logic [7:0] col_reg, col_next, row_reg, row_next;
    logic [3:0] fg_reg, fg_next, bg_reg, bg_next;
    logic bold_reg, bold_next, rev_reg, rev_next;
    logic [PW-1:0] idx_reg, idx_next;
    logic ov_reg, ov_next;
    logic [31:0] od_reg, od_next;
    logic [7:0] lc, lr, cc, cr, pr, pc;
    logic [7:0] code;

    assign lc = (cols == 8'd0) ? 8'd0 : cols - 8'd1;
    assign lr = (rows == 8'd0) ? 8'd0 : rows - 8'd1;
    assign cc = (col_reg > lc) ? lc : col_reg;
    assign cr = (row_reg > lr) ? lr : row_reg;
    assign out_valid = ov_reg;
    assign out_data = od_reg;
    assign bstat.busy = q_valid || (st_reg != atbp_pkg::BK_IDLE);
    assign bstat.walking = (st_reg == atbp_pkg::BK_SGR) || q_valid;
    assign code = prm_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= atbp_pkg::BK_IDLE;
            col_reg <= '0;
            row_reg <= '0;
            fg_reg <= 4'd7;
            bg_reg <= 4'd0;
            bold_reg <= 1'b0;
            rev_reg <= 1'b0;
            idx_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            col_reg <= col_next;
            row_reg <= row_next;
            fg_reg <= fg_next;
            bg_reg <= bg_next;
            bold_reg <= bold_next;
            rev_reg <= rev_next;
            idx_reg <= idx_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        od_reg <= od_next;
    end

    always_comb
    begin
        st_next = st_reg;
        col_next = col_reg;
        row_next = row_reg;
        fg_next = fg_reg;
        bg_next = bg_reg;
        bold_next = bold_reg;
        rev_next = rev_reg;
        idx_next = idx_reg;
        ov_next = ov_reg && !out_ready;
        od_next = od_reg;
        q_pop = 1'b0;
        prm_raddr = idx_reg[IW-1:0];
        pr = 8'd0;
        pc = 8'd0;
        // every accepted byte pulls the cursor back inside the screen
        if (in_take)
        begin
            col_next = cc;
            row_next = cr;
        end
        unique case (st_reg)
            atbp_pkg::BK_SGR:
            begin
                // one parameter per cycle
                if (idx_reg >= prm_count || code > atbp_pkg::SGR_ABORT)
                begin
                    st_next = atbp_pkg::BK_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + PW'(1);
                    if (code == 8'd0)
                    begin
                        fg_next = 4'd7;
                        bg_next = 4'd0;
                        bold_next = 1'b0;
                        rev_next = 1'b0;
                    end
                    else if (code == 8'd1)
                    begin
                        bold_next = 1'b1;
                    end
                    else if (code == 8'd7)
                    begin
                        if (!rev_reg)
                        begin
                            fg_next = bg_reg;
                            bg_next = fg_reg;
                            rev_next = 1'b1;
                        end
                    end
                    else if (code >= 8'd30 && code <= 8'd37)
                    begin
                        if (rev_reg)
                        begin
                            bg_next = {bold_reg, code[2:0] - 3'd6};
                        end
                        else
                        begin
                            fg_next = {bold_reg, code[2:0] - 3'd6};
                        end
                    end
                    else if (code >= 8'd40 && code <= 8'd47)
                    begin
                        if (rev_reg)
                        begin
                            fg_next = {1'b0, code[2:0]};
                        end
                        else
                        begin
                            bg_next = {1'b0, code[2:0]};
                        end
                    end
                end
            end
            default:
            begin
                if (q_valid && (!ov_reg || out_ready))
                begin
                    q_pop = 1'b1;
                    col_next = cc;
                    row_next = cr;
                    unique case (q_head.kind)
                        atbp_pkg::CMD_BS:
                        begin
                            if (cc != 8'd0)
                            begin
                                col_next = cc - 8'd1;
                            end
                            else if (cr != 8'd0)
                            begin
                                row_next = cr - 8'd1;
                                col_next = lc;
                            end
                            ov_next = 1'b1;
                            od_next = {bg_reg, fg_reg, 7'h20, row_next,
                                col_next, atbp_pkg::EV_DRAW};
                        end
                        atbp_pkg::CMD_LF:
                        begin
                            col_next = 8'd0;
                            if (cr >= lr)
                            begin
                                ov_next = 1'b1;
                                od_next = {31'd0, atbp_pkg::EV_SCROLL};
                            end
                            else
                            begin
                                row_next = cr + 8'd1;
                            end
                        end
                        atbp_pkg::CMD_CR:
                        begin
                            col_next = 8'd0;
                        end
                        atbp_pkg::CMD_PRINT:
                        begin
                            ov_next = 1'b1;
                            od_next = {bg_reg, fg_reg, q_head.symbol, cr, cc,
                                atbp_pkg::EV_DRAW};
                            if (cc < lc)
                            begin
                                col_next = cc + 8'd1;
                            end
                        end
                        atbp_pkg::CMD_CUP:
                        begin
                            // row from the first field, column from the second
                            prm_raddr = '0;
                            pr = (prm_count >= PW'(1)) ? prm_rdata : 8'd0;
                            pr = (pr == 8'd0) ? 8'd0 : pr - 8'd1;
                            row_next = (pr > lr) ? lr : pr;
                            pc = (prm_count >= PW'(2)) ? prm_rdata1 : 8'd0;
                            pc = (pc == 8'd0) ? 8'd0 : pc - 8'd1;
                            col_next = (pc > lc) ? lc : pc;
                        end
                        atbp_pkg::CMD_SGR:
                        begin
                            if (prm_count == '0)
                            begin
                                fg_next = 4'd7;
                                bg_next = 4'd0;
                                bold_next = 1'b0;
                                rev_next = 1'b0;
                            end
                            else
                            begin
                                idx_next = '0;
                                st_next = atbp_pkg::BK_SGR;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        endcase
    end

    `include "ansi_terminal_byte_processor_unit_macros.svh"
    `ATBP_ASSERT_IMPL(a_pop_only_idle, clk, rst_n, q_pop, st_reg == atbp_pkg::BK_IDLE)
    `ATBP_ASSERT_NEXT(a_out_hold, clk, rst_n, ov_reg && !out_ready, ov_reg)
    `ATBP_ASSERT_IMPL(a_walk_range, clk, rst_n, st_reg == atbp_pkg::BK_SGR, idx_reg <= prm_count)
endmodule

[rtl/ansi_terminal_byte_processor_unit.sv]
// top level of the terminal byte processor: apb registers, front, queue, back
// depends on atbp_pkg, atbp_front, atbp_queue, atbp_back
`timescale 1ns / 1ps
// Takes one terminal byte per cycle for text and controls while the command
// queue is not full; the event of a byte passes through that queue and then
// the output register. An SGR final byte walks its parameters one per cycle,
// and every byte after an ESC waits until the command queue is empty and that
// walk has ended. Results leave through an output register; a two entry queue
// sits between parser and executor. The cursor is pulled back inside the
// screen at each accepted byte after a screen size change.
module ansi_terminal_byte_processor_unit #(
    parameter int MAX_PARAMS = atbp_pkg::MAX_PARAMS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // event_kind, cell_column, cell_row, cell_symbol,
                                   // cell_foreground, cell_background
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int PW = $clog2(MAX_PARAMS + 1);
    localparam int IW = $clog2(MAX_PARAMS);
    logic [7:0] cols_reg, rows_reg;
    logic q_push, q_full, q_pop, q_ne;
    atbp_pkg::cmd_t q_cmd, q_head;
    atbp_pkg::back_status_t bstat;
    logic [IW-1:0] prm_raddr;
    logic [7:0] prm_rdata;
    logic [7:0] prm_rdata1;
    logic [PW-1:0] prm_count;

    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= atbp_pkg::COLS_RESET;
            rows_reg <= atbp_pkg::ROWS_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2:2] == atbp_pkg::REG_COLS[0:0] && paddr[1:0] == 2'd0)
            begin
                cols_reg <= pwdata[7:0];
            end
            else if (paddr[2:2] == atbp_pkg::REG_ROWS[0:0] && paddr[1:0] == 2'd0)
            begin
                rows_reg <= pwdata[7:0];
            end
        end
    end
    assign prdata = (paddr[2]) ? {24'd0, rows_reg} : {24'd0, cols_reg};

    atbp_front #(.MAX_PARAMS(MAX_PARAMS), .PW(PW), .IW(IW)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_byte(s_tdata), .q_push(q_push), .q_cmd(q_cmd), .q_full(q_full),
        .bstat(bstat), .prm_raddr(prm_raddr), .prm_rdata(prm_rdata),
        .prm_rdata1(prm_rdata1), .prm_count(prm_count)
    );

    atbp_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_cmd(q_cmd), .full(q_full),
        .pop(q_pop), .not_empty(q_ne), .head(q_head)
    );

    atbp_back #(.MAX_PARAMS(MAX_PARAMS), .PW(PW), .IW(IW)) u_back (
        .clk(clk), .rst_n(rst_n), .cols(cols_reg), .rows(rows_reg),
        .in_take(s_tvalid && s_tready),
        .q_valid(q_ne), .q_head(q_head), .q_pop(q_pop), .bstat(bstat),
        .prm_raddr(prm_raddr), .prm_rdata(prm_rdata), .prm_rdata1(prm_rdata1),
        .prm_count(prm_count),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
    );
endmodule

[tb/testbench.sv]
// testbench of the terminal byte processor: directed and random byte streams
// under several screen sizes, events checked against an in-bench parser model
// depends on atbp_pkg and ansi_terminal_byte_processor_unit
`timescale 1ns / 1ps
module testbench;

    typedef struct {
        logic [0:0] kind;
        logic [7:0] column;
        logic [7:0] row;
        logic [6:0] symbol;
        logic [3:0] fg;
        logic [3:0] bg;
    } cell_event_t;

    class terminal_scoreboard;
        cell_event_t expected_events[$];
        int          errors;
        logic [7:0]  columns;
        logic [7:0]  rows;
        atbp_pkg::phase_t phase;
        logic [7:0]  params[atbp_pkg::MAX_PARAMS_DEF];
        int          nparams;
        bit          halted;
        logic [7:0]  cur_col;
        logic [7:0]  cur_row;
        logic [3:0]  fg;
        logic [3:0]  bg;
        bit          bold;
        bit          reverse;

        function new();
            errors = 0;
            columns = atbp_pkg::COLS_RESET;
            rows = atbp_pkg::ROWS_RESET;
            phase = atbp_pkg::PH_TEXT;
            nparams = 0;
            halted = 0;
            cur_col = 0;
            cur_row = 0;
            plain();
        endfunction

        function void plain();
            fg = 4'd7;
            bg = 4'd0;
            bold = 0;
            reverse = 0;
        endfunction

        function logic [7:0] last_col();
            return (columns == 0) ? 8'd0 : columns - 8'd1;
        endfunction

        function logic [7:0] last_row();
            return (rows == 0) ? 8'd0 : rows - 8'd1;
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] v);
            if (idx == atbp_pkg::REG_COLS)
                columns = v;
            else if (idx == atbp_pkg::REG_ROWS)
                rows = v;
        endfunction

        function void push_draw(logic [6:0] sym);
            cell_event_t e;
            e.kind = atbp_pkg::EV_DRAW;
            e.column = cur_col;
            e.row = cur_row;
            e.symbol = sym;
            e.fg = fg;
            e.bg = bg;
            expected_events.push_back(e);
        endfunction

        function void run_sgr();
            int code;
            logic [3:0] t;
            if (nparams == 0)
            begin
                plain();
                return;
            end
            for (int i = 0; i < nparams && i < atbp_pkg::MAX_PARAMS_DEF; i++)
            begin
                code = params[i];
                if (code > atbp_pkg::SGR_ABORT)
                    return;
                if (code == 0)
                    plain();
                else if (code == 1)
                    bold = 1;
                else if (code == 7)
                begin
                    if (!reverse)
                    begin
                        t = fg;
                        fg = bg;
                        bg = t;
                        reverse = 1;
                    end
                end
                else if (code >= atbp_pkg::SGR_FG_BASE && code <= atbp_pkg::SGR_FG_BASE + 7)
                begin
                    t = 4'(code - atbp_pkg::SGR_FG_BASE) + (bold ? 4'd8 : 4'd0);
                    if (reverse) bg = t; else fg = t;
                end
                else if (code >= atbp_pkg::SGR_BG_BASE && code <= atbp_pkg::SGR_BG_BASE + 7)
                begin
                    t = 4'(code - atbp_pkg::SGR_BG_BASE);
                    if (reverse) fg = t; else bg = t;
                end
            end
        endfunction

        function void run_cup();
            int r;
            int c;
            r = (nparams >= 1) ? params[0] : 0;
            c = (nparams >= 2) ? params[1] : 0;
            if (r == 0) r = 1;
            if (c == 0) c = 1;
            r = r - 1;
            c = c - 1;
            cur_row = (r > last_row()) ? last_row() : 8'(r);
            cur_col = (c > last_col()) ? last_col() : 8'(c);
        endfunction

        function void open_field();
            if (nparams == 0)
            begin
                params[0] = 0;
                nparams = 1;
            end
        endfunction

        function void csi_byte(logic [7:0] b);
            int v;
            if (b >= 8'h20 && b <= 8'h3F)
            begin
                if (halted)
                    return;
                if (b >= 8'h30 && b <= 8'h39)
                begin
                    open_field();
                    v = params[nparams - 1] * 10 + (b - 8'h30);
                    params[nparams - 1] = (v > 255) ? 8'd255 : 8'(v);
                end
                else if (b == atbp_pkg::CH_SEMI)
                begin
                    open_field();
                    if (nparams < atbp_pkg::MAX_PARAMS_DEF)
                    begin
                        params[nparams] = 0;
                        nparams++;
                    end
                    else
                        halted = 1;
                end
                else
                    halted = 1;
                return;
            end
            if (b >= 8'h40 && b <= 8'h7E)
            begin
                if (b == atbp_pkg::CH_CUP)
                    run_cup();
                else if (b == atbp_pkg::CH_SGR)
                    run_sgr();
            end
            phase = atbp_pkg::PH_TEXT;
        endfunction

        // one accepted input byte: update state, queue the event it causes
        function void note_byte(logic [7:0] b);
            cell_event_t e;
            if (cur_col > last_col()) cur_col = last_col();
            if (cur_row > last_row()) cur_row = last_row();
            if (phase == atbp_pkg::PH_ESC)
            begin
                if (b == atbp_pkg::CH_LBRACKET)
                begin
                    phase = atbp_pkg::PH_CSI;
                    nparams = 0;
                    halted = 0;
                end
                else
                    phase = atbp_pkg::PH_TEXT;
                return;
            end
            if (phase != atbp_pkg::PH_TEXT)
            begin
                csi_byte(b);
                return;
            end
            if (b == atbp_pkg::CH_ESC)
                phase = atbp_pkg::PH_ESC;
            else if (b == atbp_pkg::CH_BS)
            begin
                if (cur_col > 0)
                    cur_col--;
                else if (cur_row > 0)
                begin
                    cur_row--;
                    cur_col = last_col();
                end
                push_draw(7'h20);
            end
            else if (b == atbp_pkg::CH_LF)
            begin
                cur_col = 0;
                if (cur_row >= last_row())
                begin
                    cur_row = last_row();
                    e = '{atbp_pkg::EV_SCROLL, 8'd0, 8'd0, 7'd0, 4'd0, 4'd0};
                    expected_events.push_back(e);
                end
                else
                    cur_row++;
            end
            else if (b == atbp_pkg::CH_CR)
                cur_col = 0;
            else if (b >= 8'h20 && b != 8'h7F)
            begin
                push_draw(b > 8'h7F ? 7'h3F : b[6:0]);
                if (cur_col < last_col())
                    cur_col++;
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_event(logic [31:0] d);
            cell_event_t e;
            if (expected_events.size() == 0)
            begin
                report($sformatf("unexpected transaction %h", d));
                return;
            end
            e = expected_events.pop_front();
            if (d[0] !== e.kind)
                report($sformatf("kind %0d, want %0d", d[0], e.kind));
            if (d[8:1] !== e.column)
                report($sformatf("column %0d, want %0d", d[8:1], e.column));
            if (d[16:9] !== e.row)
                report($sformatf("row %0d, want %0d", d[16:9], e.row));
            if (d[23:17] !== e.symbol)
                report($sformatf("symbol %h, want %h", d[23:17], e.symbol));
            if (d[27:24] !== e.fg)
                report($sformatf("foreground %0d, want %0d", d[27:24], e.fg));
            if (d[31:28] !== e.bg)
                report($sformatf("background %0d, want %0d", d[31:28], e.bg));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // in_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // event_kind, cell_column, cell_row, cell_symbol,
                             // cell_foreground, cell_background
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    terminal_scoreboard sb;
    logic [7:0] byte_q[$];
    int         cycles;
    int         events_seen;
    int         send_gap_max;

    ansi_terminal_byte_processor_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial clk = 0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task write_reg(logic [1:0] idx, logic [7:0] v);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx[0], 2'b00};
        pwdata <= {24'd0, v};
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.set_reg(idx, v);
    endtask

    task send_byte(logic [7:0] b);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= b;
        do @(posedge clk); while (!s_tready);
        sb.note_byte(b);
    endtask

    task flush_bytes();
        while (byte_q.size() > 0)
        begin
            if ($urandom_range(0, 99) == 0)
                send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
            send_byte(byte_q.pop_front());
        end
        s_tvalid <= 0;
    endtask

    task drain();
        while (sb.expected_events.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function void add_param_field();
        int v;
        case ($urandom_range(0, 5))
            0: v = -1;
            1: v = $urandom_range(0, 999);
            2: v = $urandom_range(0, 9);
            default:
            begin
                case ($urandom_range(0, 5))
                    0: v = 0;
                    1: v = 1;
                    2: v = 7;
                    3: v = $urandom_range(30, 37);
                    4: v = $urandom_range(40, 47);
                    default: v = $urandom_range(100, 255);
                endcase
            end
        endcase
        if (v >= 0)
        begin
            string s;
            s = $sformatf("%0d", v);
            for (int i = 0; i < s.len(); i++)
                byte_q.push_back(s[i]);
        end
    endfunction

    function void add_csi();
        int n;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 4);
        byte_q.push_back(atbp_pkg::CH_ESC);
        byte_q.push_back(atbp_pkg::CH_LBRACKET);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
                byte_q.push_back(atbp_pkg::CH_SEMI);
            add_param_field();
            if ($urandom_range(0, 30) == 0)
                byte_q.push_back(8'($urandom_range(0, 1) ? $urandom_range(8'h20, 8'h2F)
                                                          : $urandom_range(8'h3A, 8'h3F)));
        end
        case ($urandom_range(0, 9))
            0: byte_q.push_back(8'($urandom_range(8'h40, 8'h7E)));
            1: byte_q.push_back(8'($urandom_range(0, 1) ? $urandom_range(0, 8'h1F)
                                                        : $urandom_range(8'h7F, 8'hFF)));
            2, 3, 4: byte_q.push_back(atbp_pkg::CH_CUP);
            default: byte_q.push_back(atbp_pkg::CH_SGR);
        endcase
    endfunction

    function void add_random(int count);
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 19))
                0: add_csi();
                1: add_csi();
                2: byte_q.push_back(atbp_pkg::CH_LF);
                3: byte_q.push_back(atbp_pkg::CH_BS);
                4: byte_q.push_back(atbp_pkg::CH_CR);
                5:
                begin
                    byte_q.push_back(atbp_pkg::CH_ESC);
                    byte_q.push_back(8'($urandom_range(0, 255)));
                end
                6: byte_q.push_back(8'($urandom_range(0, 255)));
                7: byte_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
                default: byte_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
            endcase
        end
    endfunction

    // receiver: random stalls, one long hold-off so the input backs up
    initial
    begin
        int gap;
        int rx_gap_max;
        m_tready = 0;
        events_seen = 0;
        rx_gap_max = 6;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 99) == 0)
                rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
            gap = (events_seen == 40) ? 400 : $urandom_range(0, rx_gap_max);
            if (gap > 0)
            begin
                m_tready <= 0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_event(m_tdata);
            events_seen++;
        end
    end

    initial
    begin
        logic [7:0] directed[$];
        logic [7:0] col_set[6];
        logic [7:0] row_set[6];
        sb = new();
        cycles = 0;
        send_gap_max = 6;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // extremes, controls, escape cases at reset size
        directed = '{8'h41, 8'h7E, 8'hFF, 8'h00, 8'h7F, atbp_pkg::CH_BS, atbp_pkg::CH_BS,
                     atbp_pkg::CH_LF, atbp_pkg::CH_CR, atbp_pkg::CH_ESC, 8'h78,
                     atbp_pkg::CH_ESC, atbp_pkg::CH_LBRACKET, 8'h31, atbp_pkg::CH_SEMI,
                     8'h33, 8'h31, atbp_pkg::CH_SGR, 8'h5A, atbp_pkg::CH_ESC,
                     atbp_pkg::CH_LBRACKET, 8'h39, 8'h39, 8'h39, atbp_pkg::CH_CUP,
                     atbp_pkg::CH_ESC, atbp_pkg::CH_LBRACKET, atbp_pkg::CH_SEMI,
                     atbp_pkg::CH_CUP, 8'h42};
        foreach (directed[i])
            byte_q.push_back(directed[i]);
        byte_q.push_back(8'h21);
        byte_q.push_back(atbp_pkg::CH_LF);
        flush_bytes();
        add_random(150);
        flush_bytes();
        drain();

        col_set = '{8'd1, 8'd255, 8'd5, 8'd255, 8'd1, 8'd80};
        row_set = '{8'd1, 8'd255, 8'd3, 8'd1, 8'd255, 8'd25};
        for (int p = 0; p < 6; p++)
        begin
            write_reg(atbp_pkg::REG_COLS, col_set[p]);
            write_reg(atbp_pkg::REG_ROWS, row_set[p]);
            add_random(140);
            flush_bytes();
            drain();
        end
        write_reg(atbp_pkg::REG_COLS, 8'($urandom_range(1, 255)));
        write_reg(atbp_pkg::REG_ROWS, 8'($urandom_range(1, 12)));
        add_random(100);
        flush_bytes();
        drain();

        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
